// File: hw/rtl/tbps_pkg.sv
// ----------------------------------------------------------------------------
// tbps_pkg: shared types and constants for the two-bit-plane stego block
// Payload structs for the item and result channels, the configuration
// struct and the register and mode codes.
// ----------------------------------------------------------------------------
package tbps_pkg;

  localparam int BLOCK_SIDE_DEFAULT = 8;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH = 2'd2;

  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam logic [1:0] LAST_CHUNK = 2'd3;

  typedef struct packed {
    logic       block_start;
    logic [7:0] channel_byte;
    logic [7:0] message_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] channel_out;
    logic [7:0] recovered_byte;
    logic       recovered_valid;
    logic       finished;
  } out_item_t;

  typedef struct packed {
    logic       mode;
    logic [1:0] plane_select;
    logic [5:0] message_length;
  } cfg_t;

endpackage

// File: hw/rtl/tbps_cfg.sv
// ----------------------------------------------------------------------------
// tbps_cfg: configuration registers
// Holds mode, bit-plane select and message length, written by index.
// ----------------------------------------------------------------------------
module tbps_cfg import tbps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_MODE:   cfg.mode           <= wr_data[0];
        REG_PLANE:  cfg.plane_select   <= wr_data[1:0];
        REG_LENGTH: cfg.message_length <= wr_data;
        default:    ;
      endcase
    end
  end

endmodule

// File: hw/rtl/tbps_core.sv
// ----------------------------------------------------------------------------
// tbps_core: per-channel embed / extract step
// Combinational step over one channel byte plus the block counters, which
// advance on every transfer into the result register.
// ----------------------------------------------------------------------------
module tbps_core import tbps_pkg::*; #(
  parameter int BLOCK_SIDE = BLOCK_SIDE_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  localparam int CAP_INT = 3 * BLOCK_SIDE * BLOCK_SIDE;
  localparam int CS_W    = $clog2(CAP_INT + 1);
  localparam logic [CS_W-1:0] CAP = CS_W'(CAP_INT);

  logic [1:0]      chunk_position, chunk_position_next;
  logic [5:0]      bytes_done, bytes_done_next;
  logic [7:0]      held_message, held_message_next;
  logic [7:0]      extract_accumulator, extract_accumulator_next;
  logic [CS_W-1:0] channels_seen, channels_seen_next;

  logic [1:0]      cp;
  logic [5:0]      bd;
  logic [7:0]      held, acc, msg_now, acc_new, plane_mask;
  logic [CS_W-1:0] cs;
  logic [2:0]      plane_shift, chunk_shift;
  logic [1:0]      chunk_in, chunk_out;
  logic            active;

  always_comb begin
    // A block start clears the counters before this channel is handled.
    cp   = item.block_start ? 2'd0 : chunk_position;
    bd   = item.block_start ? 6'd0 : bytes_done;
    held = item.block_start ? 8'd0 : held_message;
    acc  = item.block_start ? 8'd0 : extract_accumulator;
    cs   = item.block_start ? '0 : channels_seen;

    active = (bd < cfg.message_length) && (cs < CAP);

    // Shift of 6 - 2*code, which is the inverted code followed by a zero.
    plane_shift = {~cfg.plane_select, 1'b0};
    chunk_shift = {~cp, 1'b0};
    plane_mask  = 8'h03 << plane_shift;

    msg_now   = (cp == 2'd0) ? item.message_byte : held;
    chunk_out = 2'(msg_now >> chunk_shift);
    chunk_in  = 2'(item.channel_byte >> plane_shift);
    acc_new   = acc | (8'(chunk_in) << chunk_shift);

    chunk_position_next      = cp;
    bytes_done_next          = bd;
    held_message_next        = held;
    extract_accumulator_next = acc;
    channels_seen_next       = (cs < CAP) ? cs + 1'b1 : cs;

    result.channel_out     = item.channel_byte;
    result.recovered_byte  = 8'd0;
    result.recovered_valid = 1'b0;

    if (active) begin
      if (cfg.mode == MODE_EMBED) begin
        held_message_next  = msg_now;
        result.channel_out = (item.channel_byte & ~plane_mask) |
                             (8'(chunk_out) << plane_shift);
      end else begin
        extract_accumulator_next = acc_new;
      end
      if (cp == LAST_CHUNK) begin
        chunk_position_next      = 2'd0;
        bytes_done_next          = bd + 6'd1;
        extract_accumulator_next = 8'd0;
        if (cfg.mode == MODE_EXTRACT) begin
          result.recovered_byte  = acc_new;
          result.recovered_valid = 1'b1;
        end
      end else begin
        chunk_position_next = cp + 2'd1;
      end
    end

    result.finished = (bytes_done_next >= cfg.message_length) ||
                      (channels_seen_next >= CAP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_position      <= '0;
      bytes_done          <= '0;
      held_message        <= '0;
      extract_accumulator <= '0;
      channels_seen       <= '0;
    end else if (fire) begin
      chunk_position      <= chunk_position_next;
      bytes_done          <= bytes_done_next;
      held_message        <= held_message_next;
      extract_accumulator <= extract_accumulator_next;
      channels_seen       <= channels_seen_next;
    end
  end

  a_cs_bounded: assert property (@(posedge clk) disable iff (rst)
    channels_seen <= CAP)
    else $error("channel count passed the block capacity");

  a_rec_extract_only: assert property (@(posedge clk) disable iff (rst)
    fire && result.recovered_valid |-> cfg.mode == MODE_EXTRACT)
    else $error("recovered byte flagged in embed mode");

  a_rec_wraps: assert property (@(posedge clk) disable iff (rst)
    fire && result.recovered_valid |=> chunk_position == 2'd0 &&
                                       extract_accumulator == 8'd0)
    else $error("chunk position did not wrap after a recovered byte");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(bytes_done) && $stable(channels_seen))
    else $error("counters moved without a transfer");

endmodule

// File: hw/rtl/two_bit_plane_stego_embed_extract_top.sv
// ----------------------------------------------------------------------------
// two_bit_plane_stego_embed_extract_top: two-bit-plane stego embed/extract
// Embeds message bytes into, or recovers them from, a selected bit pair of
// a stream of colour channel bytes covering one square pixel block.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------
//  in       | to block  | in_valid / in_stall   | in_data (in_item_t)
//  out      | from block| out_valid / out_stall | out_data (out_item_t)
//  cfg      | to block  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  Each channel byte passes an input register and a result register; one
//  transfer per cycle is sustained while the result side does not stall.
//  The core counters advance on the edge that loads the result register.
//  A stalled result holds the pipe; the input register takes an item while
//  it is empty or while its item moves on to the result register.
//  Synchronous reset clears valids, counters and configuration registers.
//  Configuration writes are always ready.
// ----------------------------------------------------------------------------
module two_bit_plane_stego_embed_extract_top import tbps_pkg::*; #(
  parameter int BLOCK_SIDE = BLOCK_SIDE_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_valid;
  logic      out_load, fire;
  out_item_t result;

  assign cfg_ready = 1'b1;

  tbps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_load = !out_valid || !out_stall;
  assign fire     = item_valid && out_load;
  assign in_stall = item_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_q <= in_data;
    end
  end

  tbps_core #(.BLOCK_SIDE(BLOCK_SIDE)) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the two-bit-plane stego embed/extract block
// Each accepted channel transfer is run through a local predictor of the
// embed and extract logic; each result transfer is compared field by field
// with the oldest prediction. Random stalls on both channels, one long
// receiver hold-off, and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import tbps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_SIDE    = BLOCK_SIDE_DEFAULT;
  localparam int CAPACITY      = 3 * BLOCK_SIDE * BLOCK_SIDE;
  localparam int RANDOM_ITEMS  = 850;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int LONG_HOLD     = 80;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Register copies and stego state as the block should hold them.
  logic       cur_mode  = MODE_EMBED;
  logic [1:0] cur_plane = 2'd0;
  logic [5:0] cur_len   = 6'd0;
  logic [1:0] chunk_pos = 2'd0;
  logic [5:0] bytes_done = 6'd0;
  logic [7:0] held_msg   = 8'd0;
  logic [7:0] gather_acc = 8'd0;
  int         chans_seen = 0;

  in_item_t  channel_stream[$];
  out_item_t predicted_outputs[$];

  int mismatches = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 66;
  logic long_hold_req = 1'b0;
  logic long_hold_taken = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  two_bit_plane_stego_embed_extract_top #(.BLOCK_SIDE(BLOCK_SIDE)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic out_item_t embed_extract_step(input in_item_t it);
    out_item_t  r;
    logic [2:0] plane_shift;
    logic [2:0] chunk_shift;
    logic [1:0] chunk;
    r.channel_out     = it.channel_byte;
    r.recovered_byte  = 8'd0;
    r.recovered_valid = 1'b0;
    if (it.block_start) begin
      chunk_pos  = 2'd0;
      bytes_done = 6'd0;
      held_msg   = 8'd0;
      gather_acc = 8'd0;
      chans_seen = 0;
    end
    // Plane code 3 lands on bits 1:0.
    plane_shift = 3'd6 - {cur_plane, 1'b0};
    if (bytes_done < cur_len && chans_seen < CAPACITY) begin
      chunk_shift = 3'd6 - {chunk_pos, 1'b0};
      if (cur_mode == MODE_EMBED) begin
        if (chunk_pos == 2'd0) held_msg = it.message_byte;
        chunk = 2'(held_msg >> chunk_shift);
        r.channel_out = (it.channel_byte & ~(8'h03 << plane_shift)) |
                        (8'(chunk) << plane_shift);
      end else begin
        chunk = 2'(it.channel_byte >> plane_shift);
        gather_acc = gather_acc | (8'(chunk) << chunk_shift);
      end
      chans_seen++;
      if (chunk_pos == LAST_CHUNK) begin
        chunk_pos  = 2'd0;
        bytes_done = bytes_done + 6'd1;
        if (cur_mode == MODE_EXTRACT) begin
          r.recovered_byte  = gather_acc;
          r.recovered_valid = 1'b1;
        end
        gather_acc = 8'd0;
      end else begin
        chunk_pos = chunk_pos + 2'd1;
      end
    end else if (chans_seen < CAPACITY) begin
      chans_seen++;
    end
    r.finished = (bytes_done >= cur_len) || (chans_seen >= CAPACITY);
    return r;
  endfunction

  // Channel driver: the next item is chosen only when the channel is free.
  always @(posedge clk) begin
    logic busy;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        predicted_outputs.insert(predicted_outputs.size(), embed_extract_step(in_data));
        busy = 1'b0;
      end
      if (!busy) begin
        if (channel_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= channel_stream.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side stall, with one long hold-off that lets the block fill up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_taken) begin
      out_stall       <= 1'b1;
      hold_left       <= LONG_HOLD;
      long_hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transfer with nothing predicted: %h", $realtime, out_data);
      end else begin
        want = predicted_outputs.pop_front();
        if (out_data.channel_out !== want.channel_out ||
            out_data.recovered_byte !== want.recovered_byte ||
            out_data.recovered_valid !== want.recovered_valid ||
            out_data.finished !== want.finished) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected chan %h rec %h/%b fin %b, got chan %h rec %h/%b fin %b",
                     $realtime, want.channel_out, want.recovered_byte,
                     want.recovered_valid, want.finished, out_data.channel_out,
                     out_data.recovered_byte, out_data.recovered_valid,
                     out_data.finished);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves cfg_valid high so that back-to-back writes need one assignment per edge.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE:   cur_mode  = val[0];
      REG_PLANE:  cur_plane = val[1:0];
      REG_LENGTH: cur_len   = val;
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic m, input logic [1:0] p, input logic [5:0] len);
    write_reg(REG_MODE, {5'd0, m});
    write_reg(REG_PLANE, {4'd0, p});
    write_reg(REG_LENGTH, len);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_item(input logic s, input logic [7:0] c,
                                         input logic [7:0] m);
    in_item_t it;
    it.block_start  = s;
    it.channel_byte = c;
    it.message_byte = m;
    return it;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_item(input in_item_t it);
    channel_stream.insert(channel_stream.size(), it);
  endtask

  // Queues a run of channels; a stray block start now and then breaks the run.
  task automatic queue_channels(input logic first_start, input int n);
    for (int i = 0; i < n; i++)
      queue_item(make_item(i == 0 ? first_start : ($urandom_range(39) == 0),
                           rand_byte(), rand_byte()));
  endtask

  // Waits for every transfer to come back, then lets the pipe settle.
  task automatic drain();
    while (channel_stream.size() != 0 || in_valid || predicted_outputs.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int         sent;
    int         phase;
    int         n;
    logic       m;
    logic [1:0] p;
    logic [5:0] len;
    logic       first_start;
    sent  = 0;
    phase = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Embed on the top pair, two bytes spread over all eight channels.
    set_registers(MODE_EMBED, 2'd0, 6'd2);
    @(negedge clk);
    queue_item(make_item(1'b1, 8'hFF, 8'h00));
    queue_item(make_item(1'b0, 8'h00, 8'hFF));
    queue_item(make_item(1'b0, 8'hFF, 8'hA5));
    queue_item(make_item(1'b0, 8'h00, 8'h5A));
    queue_item(make_item(1'b0, 8'hFF, 8'hC3));
    queue_item(make_item(1'b0, 8'h00, 8'h3C));
    queue_item(make_item(1'b0, 8'hFF, 8'h00));
    queue_item(make_item(1'b0, 8'h55, 8'hFF));
    drain();

    // Extract with plane code 3, which reads bits 1:0.
    set_registers(MODE_EXTRACT, 2'd3, 6'd1);
    @(negedge clk);
    queue_item(make_item(1'b1, 8'h03, 8'h00));
    queue_item(make_item(1'b0, 8'h02, 8'hFF));
    queue_item(make_item(1'b0, 8'h01, 8'h00));
    queue_item(make_item(1'b0, 8'h00, 8'hFF));
    queue_item(make_item(1'b0, 8'hFF, 8'h00));
    queue_item(make_item(1'b0, 8'hFF, 8'hFF));
    drain();

    // Zero length: everything passes unchanged and finished is set at once.
    set_registers(MODE_EMBED, 2'd2, 6'd0);
    @(negedge clk);
    queue_item(make_item(1'b1, 8'hAA, 8'hFF));
    queue_item(make_item(1'b0, 8'h55, 8'h00));
    drain();

    // Switch from embed to extract mid-byte, with no block start after it.
    set_registers(MODE_EMBED, 2'd1, 6'd3);
    @(negedge clk);
    queue_item(make_item(1'b1, 8'h00, 8'hFF));
    queue_item(make_item(1'b0, 8'hFF, 8'h00));
    queue_item(make_item(1'b0, 8'h30, 8'h81));
    drain();
    set_registers(MODE_EXTRACT, 2'd1, 6'd3);
    @(negedge clk);
    queue_item(make_item(1'b0, 8'h30, 8'h00));
    queue_item(make_item(1'b0, 8'h20, 8'hFF));
    queue_item(make_item(1'b0, 8'h10, 8'h00));
    queue_item(make_item(1'b0, 8'hFF, 8'hFF));
    queue_item(make_item(1'b0, 8'h00, 8'h00));
    queue_item(make_item(1'b0, 8'hC3, 8'hFF));
    drain();

    while (sent < RANDOM_ITEMS) begin
      if (sent < 300) begin
        send_idle_pct <= 35;
        recv_idle_pct <= 66;
      end else if (sent < 580) begin
        send_idle_pct <= 66;
        recv_idle_pct <= 35;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      first_start = 1'b1;
      if (phase == 0) begin
        // Length beyond capacity, and channels past the end of the block.
        m = MODE_EXTRACT; p = 2'd2; len = 6'd63; n = CAPACITY + 8;
      end else if (phase == 1) begin
        m = MODE_EMBED; p = 2'd0; len = 6'd48; n = CAPACITY + 4;
      end else begin
        m   = 1'($urandom_range(1));
        p   = 2'($urandom_range(3));
        len = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
        n   = ($urandom_range(11) == 0) ? $urandom_range(CAPACITY - 2, CAPACITY + 8)
                                        : 4 * len + $urandom_range(1, 6);
        first_start = ($urandom_range(9) != 0);
      end
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      if (sent >= 580 && !long_hold_req) begin
        long_hold_req <= 1'b1;
        if (n < 40) n = 40;
      end
      set_registers(m, p, len);
      @(negedge clk);
      queue_channels(first_start, n);
      sent += n;
      phase++;
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && predicted_outputs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tbps_pkg.sv
hw/rtl/tbps_cfg.sv
hw/rtl/tbps_core.sv
hw/rtl/two_bit_plane_stego_embed_extract_top.sv
tb/tb_top.sv
